// ===== src/ada_pkg.sv =====
// ----------------------------------------------------------------------------
// ada_pkg: shared types and constants of the average drop alarm
// Register indexes, reset values, field widths and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package ada_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WCNT_W  = 17;
  localparam int WSUM_W  = 25;
  localparam int TSUM_W  = 33;
  localparam int DIST_W  = 8;
  localparam int WSIZE_W = 16;
  localparam int LIMIT_W = 32;
  localparam int FILL_W  = 32;

  localparam logic [WSIZE_W-1:0] WSIZE_RST  = 16'd100;
  localparam logic [DIST_W-1:0]  MARGIN_RST = 8'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 32'd4294000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_ALARM_MARGIN = 2'd1,
    CFG_TOTAL_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_total;
    logic wavg_load;
    logic wrestart;
    logic tavg_load;
    logic out_load;
  } ada_cmd_t;

  typedef struct packed {
    logic wdiv_need;
    logic tdiv_need;
    logic div_done;
  } ada_sts_t;

endpackage

`default_nettype wire

// ===== src/ada_in_if.sv =====
// ----------------------------------------------------------------------------
// ada_in_if: sample channel
// Valid/ready channel that carries one raw converter sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ada_in_if #(
  parameter int SAMPLE_BITS = ada_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

// ===== src/ada_out_if.sv =====
// ----------------------------------------------------------------------------
// ada_out_if: result channel
// Valid/ready channel that carries one alarm result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ada_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  distance;
  logic [7:0]  window_mean;
  logic [15:0] window_fill;
  logic [7:0]  overall_mean;
  logic [31:0] overall_fill;
  logic        warmed_up;
  logic        alarm;

  modport source (output valid, output distance, output window_mean, output window_fill,
                  output overall_mean, output overall_fill, output warmed_up,
                  output alarm, input ready);
  modport sink   (input valid, input distance, input window_mean, input window_fill,
                  input overall_mean, input overall_fill, input warmed_up,
                  input alarm, output ready);
endinterface

`default_nettype wire

// ===== src/ada_div.sv =====
// ----------------------------------------------------------------------------
// ada_div: saturating 8-bit quotient divider
// Restoring divider, one compare and subtract per cycle: one overflow check
// then eight quotient bits. A quotient above 255 gives 255.
// ----------------------------------------------------------------------------
`default_nettype none

module ada_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [7:0]            quot
);

  localparam int W = ((NUM_W > DEN_W + 8) ? NUM_W : DEN_W + 8) + 1;

  logic         busy_r;
  logic         done_r;
  logic [3:0]   cnt_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] dsh_r;
  logic [7:0]   quot_r;
  logic         ge;

  assign ge   = rem_r >= dsh_r;
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if ((cnt_r == 4'd0 && ge) || cnt_r == 4'd8) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= W'(num);
      dsh_r  <= W'(den) << 8;
      quot_r <= 8'd0;
    end else if (busy_r) begin
      dsh_r <= dsh_r >> 1;
      if (cnt_r == 4'd0) begin
        if (ge) begin
          quot_r <= 8'hFF;
        end
      end else begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quot_r <= {quot_r[6:0], ge};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ada_datapath.sv =====
// ----------------------------------------------------------------------------
// ada_datapath: sums, counts, averages and result register
// Holds the configuration, the running window and total state, the shared
// divider and the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

module ada_datapath #(
  parameter int SAMPLE_BITS = ada_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ada_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ada_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ada_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]        raw_sample,
  input  wire ada_pkg::ada_cmd_t             cmd,
  output ada_pkg::ada_sts_t                  sts,
  output logic [7:0]                         distance,
  output logic [7:0]                         window_mean,
  output logic [15:0]                        window_fill,
  output logic [7:0]                         overall_mean,
  output logic [31:0]                        overall_fill,
  output logic                               warmed_up,
  output logic                               alarm
);

  localparam int DEN_W = (COUNT_BITS > ada_pkg::WCNT_W) ? COUNT_BITS : ada_pkg::WCNT_W;
  localparam int CMP_W = (COUNT_BITS > ada_pkg::LIMIT_W) ? COUNT_BITS : ada_pkg::LIMIT_W;

  logic [ada_pkg::WSIZE_W-1:0] wsize_r;
  logic [7:0]                  margin_r;
  logic [ada_pkg::LIMIT_W-1:0] limit_r;

  logic [ada_pkg::WCNT_W-1:0]  wcnt_r;
  logic [ada_pkg::WSUM_W-1:0]  wsum_r;
  logic [7:0]                  wavg_r;
  logic [COUNT_BITS-1:0]       tcnt_r;
  logic [ada_pkg::TSUM_W-1:0]  tsum_r;
  logic [7:0]                  tavg_r;
  logic [7:0]                  dist_r;

  logic [7:0]                  dist_in;
  logic [COUNT_BITS-1:0]       tcnt_inc;
  logic [ada_pkg::TSUM_W-1:0]  tsum_inc;
  logic                        tclear;
  logic                        warm;
  logic                        low;

  logic [ada_pkg::TSUM_W-1:0]  div_num;
  logic [DEN_W-1:0]            div_den;
  logic                        div_done;
  logic [7:0]                  div_quot;

  logic [7:0]  distance_r;
  logic [7:0]  window_mean_r;
  logic [15:0] window_fill_r;
  logic [7:0]  overall_mean_r;
  logic [31:0] overall_fill_r;
  logic        warmed_up_r;
  logic        alarm_r;

  assign dist_in  = raw_sample[SAMPLE_BITS-1 -: 8];
  assign tcnt_inc = tcnt_r + COUNT_BITS'(1);
  assign tsum_inc = tsum_r + ada_pkg::TSUM_W'(dist_in);
  assign tclear   = (CMP_W'(tcnt_inc) > CMP_W'(limit_r)) ||
                    (tsum_inc > ada_pkg::TSUM_W'(limit_r));

  assign warm = tcnt_r > COUNT_BITS'(wsize_r);
  assign low  = ({1'b0, dist_r} + {1'b0, margin_r}) < {1'b0, wavg_r};

  assign sts.wdiv_need = !wcnt_r[0] && (wcnt_r != '0);
  assign sts.tdiv_need = !tcnt_r[0] && (tcnt_r != '0);
  assign sts.div_done  = div_done;

  assign div_num = cmd.div_total ? tsum_r : ada_pkg::TSUM_W'(wsum_r);
  assign div_den = cmd.div_total ? DEN_W'(tcnt_r) : DEN_W'(wcnt_r);

  ada_div #(
    .NUM_W (ada_pkg::TSUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r  <= ada_pkg::WSIZE_RST;
      margin_r <= ada_pkg::MARGIN_RST;
      limit_r  <= ada_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (ada_pkg::cfg_idx_t'(cfg_index))
        ada_pkg::CFG_WINDOW_SIZE:  wsize_r  <= cfg_data[ada_pkg::WSIZE_W-1:0];
        ada_pkg::CFG_ALARM_MARGIN: margin_r <= cfg_data[7:0];
        ada_pkg::CFG_TOTAL_LIMIT:  limit_r  <= cfg_data[ada_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
      wsum_r <= '0;
      wavg_r <= '0;
      tcnt_r <= '0;
      tsum_r <= '0;
      tavg_r <= '0;
    end else begin
      if (cmd.accept) begin
        wcnt_r <= wcnt_r + ada_pkg::WCNT_W'(1);
        wsum_r <= wsum_r + ada_pkg::WSUM_W'(dist_in);
        if (tclear) begin
          tcnt_r <= '0;
          tsum_r <= '0;
        end else begin
          tcnt_r <= tcnt_inc;
          tsum_r <= tsum_inc;
        end
      end
      if (cmd.wavg_load) begin
        wavg_r <= div_quot;
      end
      if (cmd.wrestart && (wcnt_r > ada_pkg::WCNT_W'(wsize_r))) begin
        wcnt_r <= '0;
        wsum_r <= '0;
      end
      if (cmd.tavg_load) begin
        tavg_r <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dist_r <= dist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      distance_r     <= dist_r;
      window_mean_r  <= wavg_r;
      window_fill_r  <= wcnt_r[15:0];
      overall_mean_r <= tavg_r;
      overall_fill_r <= ada_pkg::FILL_W'(tcnt_r);
      warmed_up_r    <= warm;
      alarm_r        <= warm && low;
    end
  end

  assign distance     = distance_r;
  assign window_mean  = window_mean_r;
  assign window_fill  = window_fill_r;
  assign overall_mean = overall_mean_r;
  assign overall_fill = overall_fill_r;
  assign warmed_up    = warmed_up_r;
  assign alarm        = alarm_r;

endmodule

`default_nettype wire

// ===== src/ada_ctrl.sv =====
// ----------------------------------------------------------------------------
// ada_ctrl: sequencing of one sample
// Accepts an item, runs the window and total divisions in turn where their
// counts are even and nonzero, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ada_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ada_pkg::ada_sts_t sts,
  output ada_pkg::ada_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WSTART = 6'b000010,
    S_WWAIT  = 6'b000100,
    S_TSTART = 6'b001000,
    S_TWAIT  = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_WSTART;
        end
      end
      S_WSTART: begin
        if (sts.wdiv_need) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WWAIT;
        end else begin
          state_nxt = S_TSTART;
        end
      end
      S_WWAIT: begin
        if (sts.div_done) begin
          cmd.wavg_load = 1'b1;
          state_nxt     = S_TSTART;
        end
      end
      S_TSTART: begin
        cmd.wrestart  = 1'b1;
        cmd.div_total = 1'b1;
        if (sts.tdiv_need) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_TWAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_TWAIT: begin
        cmd.div_total = 1'b1;
        if (sts.div_done) begin
          cmd.tavg_load = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/average_drop_alarm_unit.sv =====
// ----------------------------------------------------------------------------
// average_drop_alarm_unit: running average drop alarm for a distance sensor
// Raw samples enter on in_ch (valid/ready); one result per sample leaves on
// out_ch with the 8-bit distance, window and long-run means and counts, the
// warm-up flag and the alarm. Registers are written through cfg_we,
// cfg_index and cfg_data: index 0 window size, 1 alarm margin, 2 total limit.
// Write them only while no sample is in flight.
// Each mean is recomputed on even counts only, by one shared restoring
// divider whose steps per quotient are start, overflow check (a saturated
// quotient finishes there), 8 bits and finish. No new sample is accepted
// while one is in process; the next one can be accepted in the cycle after
// its result is loaded into the output register.
// If the receiver stalls, the result holds in the output register while the
// next sample is accepted and processed; that sample waits for the register.
// Reset (rst_n low, synchronous) clears all sums, counts and means, drops
// the output valid and restores the register defaults 100, 10, 4294000000.
// ----------------------------------------------------------------------------
`default_nettype none

module average_drop_alarm_unit #(
  parameter int SAMPLE_BITS = ada_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = ada_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ada_in_if.sink                             in_ch,
  ada_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ada_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ada_pkg::CFG_W-1:0]     cfg_data
);

  ada_pkg::ada_cmd_t cmd;
  ada_pkg::ada_sts_t sts;

  ada_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ada_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_sample   (in_ch.raw_sample),
    .cmd          (cmd),
    .sts          (sts),
    .distance     (out_ch.distance),
    .window_mean  (out_ch.window_mean),
    .window_fill  (out_ch.window_fill),
    .overall_mean (out_ch.overall_mean),
    .overall_fill (out_ch.overall_fill),
    .warmed_up    (out_ch.warmed_up),
    .alarm        (out_ch.alarm)
  );

endmodule

`default_nettype wire
